@@ rtl/els_pkg.sv @@
// Package for the Ethernet learning switch unit: sizes, table entry type,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package els_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int PORT_COUNT  = 16;
	localparam int GROUP_BITS  = 4;

	localparam int AW     = $clog2(TABLE_DEPTH);
	localparam int CW     = $clog2(TABLE_DEPTH + 1);
	localparam int LW     = (CW > 11) ? CW : 11;
	localparam int PORT_W = 4;
	localparam int MAC_W  = 48;
	localparam int MASK_W = 16;
	localparam int MCAST_BIT = 40;

	localparam logic [2:0] CFG_ROUTING_MODE = 3'd0;
	localparam logic [2:0] CFG_RELAY_ENABLE = 3'd1;
	localparam logic [2:0] CFG_PORT_REG     = 3'd2;
	localparam logic [2:0] CFG_PORT_GROUPS  = 3'd3;
	localparam logic [2:0] CFG_MAX_ENTRIES  = 3'd4;

	localparam logic MODE_HUB   = 1'b0;
	localparam logic MODE_LEARN = 1'b1;

	localparam logic [10:0] MAX_ENTRIES_RST = 11'd1024;

	typedef enum logic [1:0] {
		DEC_DROP  = 2'd0,
		DEC_FLOOD = 2'd1,
		DEC_UNI   = 2'd2
	} decision_t;

	typedef enum logic [1:0] {
		SCAN_SRC   = 2'd0,
		SCAN_DST   = 2'd1,
		SCAN_EVICT = 2'd2
	} scan_kind_t;

	typedef struct packed {
		logic              valid;
		logic [MAC_W-1:0]  mac;
		logic [PORT_W-1:0] port;
	} entry_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECIDE,
		ST_SCAN_SRC,
		ST_LEARN,
		ST_EVICT_CHK,
		ST_EVICT_SCAN,
		ST_EVICT_WR,
		ST_SCAN_DST,
		ST_DST_CHK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic       load_in;
		logic       clr_run;
		logic       scan_start;
		scan_kind_t scan_kind;
		logic       scan_run;
		logic       wr_learn;
		logic       wr_evict;
		logic       wr_del;
		logic       res_load;
		decision_t  res_sel;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic scan_done;
		logic hit;
		logic src_ok;
		logic fast_path;
		logic over_limit;
		logic dst_ok;
		logic out_free;
	} status_t;

endpackage

@@ rtl/els_ctrl.sv @@
// Controller state machine of the Ethernet learning switch unit.
// Depends on els_pkg; drives the datapath through els_pkg::cmd_t.
module els_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  els_pkg::status_t sts,
	output els_pkg::cmd_t    cmd
);

	els_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= els_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			els_pkg::ST_CLEAR:      if (sts.clr_done) state_d = els_pkg::ST_IDLE;
			els_pkg::ST_IDLE:       if (in_valid) state_d = els_pkg::ST_DECIDE;
			els_pkg::ST_DECIDE: begin
				if (!sts.src_ok || sts.fast_path) state_d = els_pkg::ST_DONE;
				else state_d = els_pkg::ST_SCAN_SRC;
			end
			els_pkg::ST_SCAN_SRC:   if (sts.scan_done) state_d = els_pkg::ST_LEARN;
			els_pkg::ST_LEARN:      state_d = els_pkg::ST_EVICT_CHK;
			els_pkg::ST_EVICT_CHK: begin
				if (sts.over_limit) state_d = els_pkg::ST_EVICT_SCAN;
				else state_d = els_pkg::ST_SCAN_DST;
			end
			els_pkg::ST_EVICT_SCAN: if (sts.scan_done) state_d = els_pkg::ST_EVICT_WR;
			els_pkg::ST_EVICT_WR:   state_d = els_pkg::ST_EVICT_CHK;
			els_pkg::ST_SCAN_DST:   if (sts.scan_done) state_d = els_pkg::ST_DST_CHK;
			els_pkg::ST_DST_CHK:    state_d = els_pkg::ST_DONE;
			els_pkg::ST_DONE:       if (sts.out_free) state_d = els_pkg::ST_IDLE;
			default:                state_d = els_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.scan_kind = els_pkg::SCAN_SRC;
		cmd.res_sel = els_pkg::DEC_DROP;
		in_ready = 1'b0;
		unique case (state_q)
			els_pkg::ST_CLEAR: cmd.clr_run = 1'b1;
			els_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load_in = in_valid;
			end
			els_pkg::ST_DECIDE: begin
				if (!sts.src_ok) begin
					cmd.res_load = 1'b1;
					cmd.res_sel = els_pkg::DEC_DROP;
				end else if (sts.fast_path) begin
					cmd.res_load = 1'b1;
					cmd.res_sel = els_pkg::DEC_FLOOD;
				end else begin
					cmd.scan_start = 1'b1;
					cmd.scan_kind = els_pkg::SCAN_SRC;
				end
			end
			els_pkg::ST_SCAN_SRC, els_pkg::ST_EVICT_SCAN, els_pkg::ST_SCAN_DST:
				cmd.scan_run = 1'b1;
			els_pkg::ST_LEARN: cmd.wr_learn = 1'b1;
			els_pkg::ST_EVICT_CHK: begin
				cmd.scan_start = 1'b1;
				cmd.scan_kind = sts.over_limit ? els_pkg::SCAN_EVICT : els_pkg::SCAN_DST;
			end
			els_pkg::ST_EVICT_WR: cmd.wr_evict = 1'b1;
			els_pkg::ST_DST_CHK: begin
				cmd.res_load = 1'b1;
				if (sts.hit && sts.dst_ok) begin
					cmd.res_sel = els_pkg::DEC_UNI;
				end else begin
					cmd.res_sel = els_pkg::DEC_FLOOD;
					cmd.wr_del = sts.hit;
				end
			end
			els_pkg::ST_DONE: cmd.out_load = sts.out_free;
			default: ;
		endcase
	end

endmodule

@@ rtl/els_dpath.sv @@
// Datapath of the Ethernet learning switch unit: configuration registers, MAC table
// memory with its scan engine, entry count, victim pointer and result register.
// Depends on els_pkg; commanded by els_ctrl.
module els_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [2:0]                  cfg_index,
	input  logic [63:0]                 cfg_data,
	input  logic [els_pkg::PORT_W-1:0]  source_port,
	input  logic [els_pkg::MAC_W-1:0]   dest_mac,
	input  logic [els_pkg::MAC_W-1:0]   src_mac,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [els_pkg::MASK_W-1:0]  target_mask,
	output logic [1:0]                  decision,
	input  els_pkg::cmd_t               cmd,
	output els_pkg::status_t            sts
);

	localparam int AW = els_pkg::AW;
	localparam int CW = els_pkg::CW;
	localparam int LW = els_pkg::LW;
	localparam logic [AW-1:0] LAST_IDX = AW'(els_pkg::TABLE_DEPTH - 1);
	localparam logic [AW:0]   DEPTH_N  = (AW+1)'(els_pkg::TABLE_DEPTH);
	localparam logic [CW-1:0] DEPTH_C  = CW'(els_pkg::TABLE_DEPTH);

	// configuration
	logic        routing_mode_q;
	logic        relay_enable_q;
	logic [15:0] port_registered_q;
	logic [63:0] port_groups_q;
	logic [10:0] max_entries_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			routing_mode_q    <= els_pkg::MODE_HUB;
			relay_enable_q    <= 1'b0;
			port_registered_q <= '0;
			port_groups_q     <= '0;
			max_entries_q     <= els_pkg::MAX_ENTRIES_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				els_pkg::CFG_ROUTING_MODE: routing_mode_q    <= cfg_data[0];
				els_pkg::CFG_RELAY_ENABLE: relay_enable_q    <= cfg_data[0];
				els_pkg::CFG_PORT_REG:     port_registered_q <= cfg_data[15:0];
				els_pkg::CFG_PORT_GROUPS:  port_groups_q     <= cfg_data;
				els_pkg::CFG_MAX_ENTRIES:  max_entries_q     <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	function automatic logic port_exists(input logic [els_pkg::PORT_W-1:0] p,
	                                     input logic [15:0] regs);
		return (32'(p) < els_pkg::PORT_COUNT) && regs[p];
	endfunction

	function automatic logic [els_pkg::GROUP_BITS-1:0] group_of(
			input logic [els_pkg::PORT_W-1:0] p, input logic [63:0] groups);
		return groups[32'(p) * els_pkg::GROUP_BITS +: els_pkg::GROUP_BITS];
	endfunction

	function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
		return (i == LAST_IDX) ? '0 : i + AW'(1);
	endfunction

	// frame header
	logic [els_pkg::PORT_W-1:0] src_port_q;
	logic [els_pkg::MAC_W-1:0]  dmac_q;
	logic [els_pkg::MAC_W-1:0]  smac_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			src_port_q <= source_port;
			dmac_q     <= dest_mac;
			smac_q     <= src_mac;
		end
	end

	logic [els_pkg::MASK_W-1:0] flood;
	always_comb begin
		flood = '0;
		for (int p = 0; p < els_pkg::PORT_COUNT; p++) begin
			if ((els_pkg::PORT_W'(p) != src_port_q) && port_registered_q[p] &&
			    (relay_enable_q || group_of(els_pkg::PORT_W'(p), port_groups_q) !=
			     group_of(src_port_q, port_groups_q)))
				flood[p] = 1'b1;
		end
	end

	// table state
	els_pkg::entry_t mem [els_pkg::TABLE_DEPTH];
	els_pkg::entry_t rd_s1;
	logic            rd_vld_s1;
	logic [AW-1:0]   rd_idx_s1;

	logic [AW:0]     clr_q;
	logic [AW-1:0]   addr_q;
	logic [AW:0]     issued_q;
	els_pkg::scan_kind_t kind_q;
	logic            hit_q;
	logic [AW-1:0]   hit_idx_q;
	logic [els_pkg::PORT_W-1:0] hit_port_q;
	logic            free_q;
	logic [AW-1:0]   free_idx_q;
	logic [CW-1:0]   cnt_q;
	logic [AW-1:0]   vp_q;

	logic stop, issue, full;
	assign stop  = hit_q && (kind_q != els_pkg::SCAN_SRC);
	assign issue = cmd.scan_run && (issued_q != DEPTH_N) && !stop;
	assign full  = (cnt_q >= DEPTH_C);

	// write port
	logic            we;
	logic [AW-1:0]   wa;
	els_pkg::entry_t wd;
	always_comb begin
		we = 1'b0;
		wa = hit_idx_q;
		wd = '{valid: 1'b0, mac: smac_q, port: src_port_q};
		priority if (cmd.clr_run) begin
			we = !clr_q[AW];
			wa = clr_q[AW-1:0];
		end else if (cmd.wr_learn) begin
			we = 1'b1;
			wd.valid = 1'b1;
			if (hit_q) wa = hit_idx_q;
			else if (full) wa = vp_q;
			else wa = free_idx_q;
		end else if (cmd.wr_evict || cmd.wr_del) begin
			we = 1'b1;
			wa = hit_idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (issue) rd_s1 <= mem[addr_q];
		rd_idx_s1 <= addr_q;
	end

	logic match;
	always_comb begin
		unique case (kind_q)
			els_pkg::SCAN_SRC:   match = rd_s1.valid && (rd_s1.mac == smac_q);
			els_pkg::SCAN_DST:   match = rd_s1.valid && (rd_s1.mac == dmac_q);
			default:             match = rd_s1.valid;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			addr_q    <= '0;
			issued_q  <= '0;
			kind_q    <= els_pkg::SCAN_SRC;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
			cnt_q     <= '0;
			vp_q      <= '0;
		end else begin
			if (cmd.clr_run && !clr_q[AW]) clr_q <= clr_q + (AW+1)'(1);
			rd_vld_s1 <= issue;
			if (cmd.scan_start) begin
				addr_q   <= (cmd.scan_kind == els_pkg::SCAN_EVICT) ? vp_q : '0;
				issued_q <= '0;
				kind_q   <= cmd.scan_kind;
				hit_q    <= 1'b0;
				free_q   <= 1'b0;
			end else begin
				if (issue) begin
					addr_q   <= next_idx(addr_q);
					issued_q <= issued_q + (AW+1)'(1);
				end
				if (rd_vld_s1 && match && !hit_q) hit_q <= 1'b1;
				if (rd_vld_s1 && !rd_s1.valid && !free_q) free_q <= 1'b1;
			end
			if (cmd.wr_learn && !hit_q) begin
				// full table: the victim pointer's entry is overwritten
				if (full) vp_q <= next_idx(vp_q);
				else cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.wr_evict) begin
				cnt_q <= cnt_q - CW'(1);
				vp_q  <= next_idx(hit_idx_q);
			end
			if (cmd.wr_del) cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd.scan_start && rd_vld_s1 && match && !hit_q) begin
			hit_idx_q  <= rd_idx_s1;
			hit_port_q <= rd_s1.port;
		end
		if (!cmd.scan_start && rd_vld_s1 && !rd_s1.valid && !free_q)
			free_idx_q <= rd_idx_s1;
	end

	// result and output register
	logic [els_pkg::MASK_W-1:0] res_mask_q;
	els_pkg::decision_t         res_dec_q;
	logic                       out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_dec_q <= cmd.res_sel;
			unique case (cmd.res_sel)
				els_pkg::DEC_FLOOD: res_mask_q <= flood;
				els_pkg::DEC_UNI:   res_mask_q <= (hit_port_q == src_port_q) ? '0 :
				                    (els_pkg::MASK_W'(1) << hit_port_q);
				default:            res_mask_q <= '0;
			endcase
		end
		if (cmd.out_load) begin
			target_mask <= res_mask_q;
			decision    <= res_dec_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end
	assign out_valid = out_valid_q;

	assign sts.clr_done   = clr_q[AW];
	assign sts.scan_done  = ((issued_q == DEPTH_N) || stop) && !rd_vld_s1;
	assign sts.hit        = hit_q;
	assign sts.src_ok     = port_exists(src_port_q, port_registered_q);
	assign sts.fast_path  = (routing_mode_q != els_pkg::MODE_LEARN) || dmac_q[els_pkg::MCAST_BIT];
	assign sts.over_limit = LW'(cnt_q) > LW'(max_entries_q);
	assign sts.dst_ok     = port_exists(hit_port_q, port_registered_q);
	assign sts.out_free   = !out_valid_q || out_ready;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C) else $error("entry count beyond table depth");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wr_learn, cmd.wr_evict, cmd.wr_del}))
		else $error("two table writes in one cycle");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q) else $error("result not presented");
	a_evict_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_evict |-> hit_q) else $error("eviction without a victim");

endmodule

@@ rtl/ethernet_learning_switch_unit.sv @@
// Ethernet learning switch unit: per-frame egress port selection with MAC learning.
// Instantiates els_ctrl (state machine) and els_dpath (table and result logic).
// Uses els_pkg.
//
// Input channel (in_valid/in_ready) takes one frame header: source_port, dest_mac,
// src_mac. Output channel (out_valid/out_ready) returns target_mask and decision.
// A plain write port (cfg_wr_en, cfg_index, cfg_data) sets routing mode, relay,
// registered ports, port groups and the entry limit; write only while idle.
// An unregistered source or a hub/multicast frame skips the table: DECIDE loads the
// result and DONE moves it to the output register, which raises out_valid.
// A learning frame walks the table with one read per cycle: the source scan reads
// every entry, the destination scan stops at a hit, and each eviction scans from
// the victim pointer to the first valid entry. A header is taken only in IDLE.
// After reset the table is swept invalid, one entry a cycle; in_ready stays low
// until the sweep is done. A stalled receiver holds the result in the output
// register; the next header is still taken and processed, then waits until the
// output frees.
module ethernet_learning_switch_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [2:0]                  cfg_index,
	input  logic [63:0]                 cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [els_pkg::PORT_W-1:0]  source_port,
	input  logic [els_pkg::MAC_W-1:0]   dest_mac,
	input  logic [els_pkg::MAC_W-1:0]   src_mac,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [els_pkg::MASK_W-1:0]  target_mask,
	output logic [1:0]                  decision
);

	els_pkg::cmd_t    cmd;
	els_pkg::status_t sts;

	els_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	els_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.source_port (source_port),
		.dest_mac    (dest_mac),
		.src_mac     (src_mac),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.target_mask (target_mask),
		.decision    (decision),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

@@ tb/sv/els_checker.sv @@
// Scoreboard for the Ethernet learning switch unit: tracks register writes, predicts
// the egress mask and decision of every accepted header, and compares each result.
// Uses els_pkg.
module els_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [2:0]                  cfg_index,
	input  logic [63:0]                 cfg_data,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [els_pkg::PORT_W-1:0]  source_port,
	input  logic [els_pkg::MAC_W-1:0]   dest_mac,
	input  logic [els_pkg::MAC_W-1:0]   src_mac,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [els_pkg::MASK_W-1:0]  target_mask,
	input  logic [1:0]                  decision,
	output int                          fail_count,
	output int                          pending,
	output int                          n_drop,
	output int                          n_flood,
	output int                          n_uni
);

	typedef struct {
		logic [els_pkg::MASK_W-1:0] mask;
		els_pkg::decision_t         dec;
	} egress_t;

	egress_t                    egress_q[$];
	logic                       mac_vld[els_pkg::TABLE_DEPTH];
	logic [els_pkg::MAC_W-1:0]  mac_addr[els_pkg::TABLE_DEPTH];
	logic [els_pkg::PORT_W-1:0] mac_port[els_pkg::TABLE_DEPTH];
	int unsigned                n_entries;
	int unsigned                victim;

	logic              mode;
	logic              relay;
	logic [15:0]       port_reg;
	logic [63:0]       groups;
	logic [10:0]       max_ent;

	function automatic bit port_on(int p);
		return p < els_pkg::PORT_COUNT && port_reg[p];
	endfunction

	function automatic logic [els_pkg::MASK_W-1:0] flood_ports(int s);
		logic [els_pkg::MASK_W-1:0] m;
		m = '0;
		for (int p = 0; p < els_pkg::PORT_COUNT; p++)
			if (p != s && port_on(p) &&
			    (relay || groups[p*els_pkg::GROUP_BITS +: els_pkg::GROUP_BITS] !=
			     groups[s*els_pkg::GROUP_BITS +: els_pkg::GROUP_BITS]))
				m[p] = 1'b1;
		return m;
	endfunction

	function automatic int find_addr(logic [els_pkg::MAC_W-1:0] a);
		for (int i = 0; i < els_pkg::TABLE_DEPTH; i++)
			if (mac_vld[i] && mac_addr[i] == a)
				return i;
		return -1;
	endfunction

	function automatic void evict_next();
		int unsigned i;
		i = victim % els_pkg::TABLE_DEPTH;
		for (int k = 0; k < els_pkg::TABLE_DEPTH; k++) begin
			if (mac_vld[i]) begin
				mac_vld[i] = 1'b0;
				if (n_entries > 0) n_entries--;
				victim = (i + 1) % els_pkg::TABLE_DEPTH;
				return;
			end
			i = (i + 1) % els_pkg::TABLE_DEPTH;
		end
	endfunction

	function automatic void learn_addr(logic [els_pkg::MAC_W-1:0] a,
	                                   logic [els_pkg::PORT_W-1:0] p);
		int hit;
		int unsigned lim;
		hit = find_addr(a);
		lim = (max_ent > els_pkg::TABLE_DEPTH) ? els_pkg::TABLE_DEPTH : max_ent;
		if (hit >= 0) begin
			mac_port[hit] = p;
		end else begin
			if (n_entries >= els_pkg::TABLE_DEPTH) evict_next();
			for (int i = 0; i < els_pkg::TABLE_DEPTH; i++)
				if (!mac_vld[i]) begin
					mac_vld[i]  = 1'b1;
					mac_addr[i] = a;
					mac_port[i] = p;
					n_entries++;
					break;
				end
		end
		while (n_entries > lim) evict_next();
	endfunction

	function automatic egress_t forward(logic [els_pkg::PORT_W-1:0] sp,
	                                    logic [els_pkg::MAC_W-1:0] da,
	                                    logic [els_pkg::MAC_W-1:0] sa);
		egress_t r;
		int hit;
		r.mask = '0;
		r.dec  = els_pkg::DEC_DROP;
		if (port_on(sp)) begin
			if (mode != els_pkg::MODE_LEARN || da[els_pkg::MCAST_BIT]) begin
				r.mask = flood_ports(sp);
				r.dec  = els_pkg::DEC_FLOOD;
			end else begin
				learn_addr(sa, sp);
				hit = find_addr(da);
				if (hit < 0) begin
					r.mask = flood_ports(sp);
					r.dec  = els_pkg::DEC_FLOOD;
				end else if (!port_on(mac_port[hit])) begin
					// stale entry: drop it and flood
					mac_vld[hit] = 1'b0;
					if (n_entries > 0) n_entries--;
					r.mask = flood_ports(sp);
					r.dec  = els_pkg::DEC_FLOOD;
				end else begin
					if (mac_port[hit] != sp) r.mask[mac_port[hit]] = 1'b1;
					r.dec = els_pkg::DEC_UNI;
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		egress_t e;
		egress_t got;
		if (!arst_n) begin
			for (int i = 0; i < els_pkg::TABLE_DEPTH; i++) mac_vld[i] = 1'b0;
			n_entries  = 0;
			victim     = 0;
			mode       = els_pkg::MODE_HUB;
			relay      = 1'b0;
			port_reg   = '0;
			groups     = '0;
			max_ent    = els_pkg::MAX_ENTRIES_RST;
			fail_count = 0;
			pending    = 0;
			n_drop     = 0;
			n_flood    = 0;
			n_uni      = 0;
			egress_q.delete();
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					els_pkg::CFG_ROUTING_MODE: mode     = cfg_data[0];
					els_pkg::CFG_RELAY_ENABLE: relay    = cfg_data[0];
					els_pkg::CFG_PORT_REG:     port_reg = cfg_data[15:0];
					els_pkg::CFG_PORT_GROUPS:  groups   = cfg_data;
					els_pkg::CFG_MAX_ENTRIES:  max_ent  = cfg_data[10:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				e = forward(source_port, dest_mac, src_mac);
				egress_q.push_back(e);
			end
			if (out_valid && out_ready) begin
				if (egress_q.size() == 0) begin
					$error("unexpected result: target_mask %h decision %0d",
					       target_mask, decision);
					fail_count++;
				end else begin
					got = egress_q.pop_front();
					if (target_mask !== got.mask) begin
						$error("target_mask mismatch: expected %h actual %h",
						       got.mask, target_mask);
						fail_count++;
					end
					if (decision !== got.dec) begin
						$error("decision mismatch: expected %0d actual %0d",
						       got.dec, decision);
						fail_count++;
					end
					case (got.dec)
						els_pkg::DEC_DROP:  n_drop++;
						els_pkg::DEC_FLOOD: n_flood++;
						default:            n_uni++;
					endcase
				end
			end
			pending = egress_q.size();
		end
	end

endmodule

@@ tb/sv/tb_top.sv @@
// Top of the Ethernet learning switch unit testbench: clock, reset, register writes,
// header stimulus with bursts and gaps, output stalls and the verdict.
// Uses els_pkg, els_checker and ethernet_learning_switch_unit.
module tb_top;

	localparam int CYCLE_LIMIT = 6000000;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_wr_en;
	logic [2:0]                 cfg_index;
	logic [63:0]                cfg_data;
	logic                       in_valid;
	logic                       in_ready;
	logic [els_pkg::PORT_W-1:0] source_port;
	logic [els_pkg::MAC_W-1:0]  dest_mac;
	logic [els_pkg::MAC_W-1:0]  src_mac;
	logic                       out_valid;
	logic                       out_ready;
	logic [els_pkg::MASK_W-1:0] target_mask;
	logic [1:0]                 decision;

	int fail_count, pending, n_drop, n_flood, n_uni;
	bit hold_req;
	logic [els_pkg::MAC_W-1:0] pool[8];

	ethernet_learning_switch_unit i_dut (.*);

	els_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("ethernet_learning_switch_unit test failed");
				$finish;
			end
		end
	end

	// receiver: random stalls in stretches, plus one long hold-off on request
	initial begin
		int mode_cnt;
		bit busy;
		mode_cnt = 0;
		busy = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				mode_cnt++;
				if (mode_cnt % 150 == 0) busy = $urandom_range(0, 1);
				out_ready <= busy ? ($urandom_range(0, 3) == 0) : 1'b1;
			end
		end
	end

	task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// offer one header and return right after the edge that accepts it
	task automatic send_hdr(logic [els_pkg::PORT_W-1:0] sp, logic [els_pkg::MAC_W-1:0] da,
	                        logic [els_pkg::MAC_W-1:0] sa);
		in_valid    <= 1'b1;
		source_port <= sp;
		dest_mac    <= da;
		src_mac     <= sa;
		forever begin
			@(negedge clk);
			if (in_ready) break;
		end
		@(posedge clk);
	endtask

	// drop valid and wait until every result has drained
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_all(logic m, logic r, logic [15:0] pr, logic [63:0] g, logic [10:0] me);
		cfg_write(els_pkg::CFG_ROUTING_MODE, {63'd0, m});
		cfg_write(els_pkg::CFG_RELAY_ENABLE, {63'd0, r});
		cfg_write(els_pkg::CFG_PORT_REG, {48'd0, pr});
		cfg_write(els_pkg::CFG_PORT_GROUPS, g);
		cfg_write(els_pkg::CFG_MAX_ENTRIES, {53'd0, me});
	endtask

	function automatic logic [els_pkg::MAC_W-1:0] rand_mac();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[els_pkg::MAC_W-1:0];
	endfunction

	initial begin
		logic [els_pkg::MAC_W-1:0] ma, mb, da;
		logic [10:0] lims[8];
		int burst, gap;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		source_port = '0;
		dest_mac = '0;
		src_mac = '0;
		hold_req = 1'b0;
		lims = '{11'd0, 11'd1, 11'd2, 11'd3, 11'd5, 11'd1024, 11'd2047, 11'd8};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// wait out the table sweep before touching registers
		do @(negedge clk); while (!in_ready);
		@(posedge clk);

		// no registered port: everything drops
		send_hdr(4'd0, '0, '0);
		drain();
		// hub mode, mixed groups, relay off then on
		set_all(els_pkg::MODE_HUB, 1'b0, 16'hA5FF, 64'h0123_4567_89AB_CDEF, 11'd1024);
		send_hdr(4'd0, '0, '0);
		send_hdr(4'd15, '1, '1);
		send_hdr(4'd9, 48'h0100_0000_0000, 48'h0000_0000_0001);
		drain();
		cfg_write(els_pkg::CFG_PORT_GROUPS, 64'h0);
		send_hdr(4'd15, 48'h1234_5678_9ABC, 48'h0F0F_0F0F_0F0F);
		drain();
		cfg_write(els_pkg::CFG_RELAY_ENABLE, 64'd1);
		send_hdr(4'd15, 48'h1234_5678_9ABC, 48'h0F0F_0F0F_0F0F);
		drain();

		// switch mode: learn, unicast, hit on own port, multicast, stale entry
		ma = 48'h0200_0000_00AA;
		mb = 48'hFEFF_FFFF_FF55;
		set_all(els_pkg::MODE_LEARN, 1'b0, 16'hFFFF, 64'h1111_2222_3333_4444, 11'd2047);
		send_hdr(4'd3, mb, ma);
		send_hdr(4'd5, ma, mb);
		send_hdr(4'd3, ma, ma);
		send_hdr(4'd1, 48'h0100_5E00_0001, ma);
		send_hdr(4'd7, mb, ma);
		drain();
		cfg_write(els_pkg::CFG_PORT_REG, 64'hFFDF);
		send_hdr(4'd3, mb, ma);
		send_hdr(4'd3, mb, ma);
		send_hdr(4'd5, ma, mb);
		drain();
		// entry limit of zero empties the table on each learn; limit one evicts
		cfg_write(els_pkg::CFG_MAX_ENTRIES, 64'd0);
		send_hdr(4'd2, ma, mb);
		send_hdr(4'd4, mb, ma);
		drain();
		cfg_write(els_pkg::CFG_MAX_ENTRIES, 64'd1);
		send_hdr(4'd2, ma, mb);
		send_hdr(4'd4, mb, ma);
		send_hdr(4'd2, ma, mb);
		drain();

		// hold off the receiver while hub-mode headers pile up
		cfg_write(els_pkg::CFG_ROUTING_MODE, {63'd0, els_pkg::MODE_HUB});
		hold_req = 1'b1;
		for (int i = 0; i < 12; i++) send_hdr(4'($urandom_range(0, 15)), rand_mac(), rand_mac());
		drain();

		// random phases in learning and hub mode with well-formed traffic over a small MAC pool
		for (int ph = 0; ph < 8; ph++) begin
			set_all((ph % 4 == 3) ? els_pkg::MODE_HUB : els_pkg::MODE_LEARN,
			        1'($urandom_range(0, 1)),
			        (ph == 0) ? 16'hFFFF : (ph == 5) ? 16'h8001 : 16'($urandom | 16'h0F0F),
			        {$urandom, $urandom}, lims[ph]);
			for (int i = 0; i < 8; i++) pool[i] = rand_mac() & ~(48'h1 << els_pkg::MCAST_BIT);
			burst = $urandom_range(1, 8);
			for (int i = 0; i < 33; i++) begin
				da = pool[$urandom_range(0, 7)];
				if ($urandom_range(0, 9) == 0) da = rand_mac();
				if ($urandom_range(0, 7) == 0) da[els_pkg::MCAST_BIT] = 1'b1;
				send_hdr(4'($urandom_range(0, 15)), da,
				         ($urandom_range(0, 9) == 0) ? rand_mac() : pool[$urandom_range(0, 7)]);
				burst--;
				if (burst == 0) begin
					burst = $urandom_range(1, 8);
					gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
					if (gap != 0) begin
						in_valid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				end
			end
			drain();
			// unregister ports 8 to 15 mid-run so stale table entries get hit
			if (ph == 2) begin
				cfg_write(els_pkg::CFG_PORT_REG, 64'h00FF);
				for (int i = 0; i < 6; i++) send_hdr(4'($urandom_range(0, 7)), pool[i], pool[7]);
				drain();
			end
		end

		drain();
		$display("Covered %0d results: %0d dropped, %0d flooded, %0d unicast,",
		         n_drop + n_flood + n_uni, n_drop, n_flood, n_uni);
		$display("over hub and switch modes, relay on and off, and entry limits 0 to 2047.");
		if (fail_count == 0) begin
			$display("ethernet_learning_switch_unit test passed");
		end else begin
			$display("ethernet_learning_switch_unit test failed");
		end
		$finish;
	end

endmodule
